/* rtl/clu_pkg.sv */
// Shared widths, codes and types of the clipmap level update block.
package clu_pkg;

    // Field widths
    localparam int CAM_W      = 24;
    localparam int OFF_W      = 25;
    localparam int CLIP_W     = 13;
    localparam int BASE_W     = 15;
    localparam int LVL_W      = 4;
    localparam int DST_W      = 24;
    localparam int SH_W       = 5;
    // Box numerator: twice the offset, minus clip_size << level, plus base_size
    localparam int NUM_W      = 30;

    // Stream and configuration widths
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 168;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE = 1'b1;

    // Reset values and defaults
    localparam logic [CLIP_W-1:0] CLIP_SIZE_RST = 13'd256;
    localparam logic [BASE_W-1:0] BASE_SIZE_RST = 15'd4096;
    localparam int LEVELS_DEF = 8;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic             load;
        logic             calc;
        logic             fin;
        logic [LVL_W-1:0] level;
        logic             last;
    } t_cmd;

endpackage

/* rtl/clu_ctrl.sv */
// Sequencer: walks the clip levels of one camera update and tracks the output slot.
module clu_ctrl #(
    parameter int LEVELS = clu_pkg::LEVELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output clu_pkg::t_cmd o_cmd
);
    import clu_pkg::*;

    localparam int IDX_W = (LEVELS - 1 > 1) ? $clog2(LEVELS - 1) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             r_out_full, n_out_full;
    logic             w_slot_free;
    t_cmd             w_cmd;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        w_cmd       = '0;
        w_cmd.level = LVL_W'(r_cnt);
        w_cmd.last  = (r_cnt == IDX_W'(LEVELS - 2));
        w_slot_free = !r_out_full || i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_CALC;
                end
            end
            ST_CALC: begin
                w_cmd.calc = 1'b1;
                n_state    = ST_FIN;
            end
            ST_FIN: begin
                if (w_slot_free) begin
                    w_cmd.fin = 1'b1;
                    if (w_cmd.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt   = r_cnt + IDX_W'(1);
                        n_state = ST_CALC;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_full = w_cmd.fin | (r_out_full & ~i_out_ready);
    end

    // Hold state, level count and output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_out_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_out_full <= n_out_full;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_full;
    assign o_cmd       = w_cmd;

endmodule

/* rtl/clu_datapath.sv */
// Datapath: camera registers, trim bits, per-level snap and source box arithmetic.
module clu_datapath #(
    parameter int LEVELS = clu_pkg::LEVELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  clu_pkg::t_cmd                    i_cmd,
    input  logic [clu_pkg::CAM_W-1:0]        i_cam_x,
    input  logic [clu_pkg::CAM_W-1:0]        i_cam_z,
    input  logic                             i_force,
    input  logic                             i_cfg_we,
    input  logic [clu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [clu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic [clu_pkg::OUT_TDATA_W-1:0]  o_data,
    output logic                             o_last
);
    import clu_pkg::*;

    localparam int DEPTH = LEVELS - 1;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic [BASE_W-1:0] lo;
        logic [BASE_W-1:0] hi;
        logic [DST_W-1:0]  dst;
    } t_box;

    // Clamp a numerator to [0, 2 * base_size]
    function automatic logic [BASE_W:0] f_clamp(input logic [NUM_W-1:0] num,
                                                input logic [BASE_W:0]  s2);
        logic [BASE_W:0] res;
        if (num[NUM_W-1]) begin
            res = '0;
        end else if (num > NUM_W'(s2)) begin
            res = s2;
        end else begin
            res = num[BASE_W:0];
        end
        return res;
    endfunction

    // Clamp and truncate both box edges; give the destination for a negative start
    function automatic t_box f_box(input logic [NUM_W-1:0] num,
                                   input logic [NUM_W-1:0] top,
                                   input logic [BASE_W:0]  s2,
                                   input logic [SH_W-1:0]  sh);
        logic [BASE_W:0]  lo_c;
        logic [BASE_W:0]  hi_c;
        logic [NUM_W-1:0] neg;
        logic [NUM_W-1:0] q;
        t_box             b;
        lo_c  = f_clamp(num, s2);
        hi_c  = f_clamp(top, s2);
        neg   = (NUM_W'(1) << sh) - num;
        q     = neg >> sh;
        b.lo  = BASE_W'(lo_c >> sh);
        b.hi  = BASE_W'(hi_c >> sh);
        b.dst = '0;
        if (num[NUM_W-1]) begin
            b.dst = (|q[NUM_W-1:DST_W]) ? {DST_W{1'b1}} : q[DST_W-1:0];
        end
        return b;
    endfunction

    logic [CAM_W-1:0]  r_cam_x, r_cam_z;
    logic              r_force;
    logic [CLIP_W-1:0] r_clip;
    logic [BASE_W-1:0] r_base;
    logic              r_trim_x [DEPTH];
    logic              r_trim_z [DEPTH];

    logic [NUM_W-1:0]  r_num_x, r_hi_x, r_num_z, r_hi_z;
    logic [OFF_W-1:0]  r_ox, r_oz;
    logic              r_tx, r_tz, r_copy;

    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_last;

    logic [IDX_W-1:0]  w_idx;
    logic [SH_W-1:0]   w_sh;
    logic [CAM_W-1:0]  w_mask, w_cx_snap, w_cz_snap;
    logic [OFF_W-1:0]  w_g2, w_ox, w_oz, w_oz_d;
    logic [NUM_W-1:0]  w_2ox, w_2oz, w_ngi, w_base;
    logic              w_tx, w_tz, w_copy;
    t_box              w_bx, w_bz;

    // Snap the centre and form the box numerators of the current level
    always_comb begin
        w_idx     = i_cmd.level[IDX_W-1:0];
        w_sh      = SH_W'(i_cmd.level) + SH_W'(1);
        w_mask    = {CAM_W{1'b1}} << w_sh;
        w_cx_snap = r_cam_x & w_mask;
        w_cz_snap = r_cam_z & w_mask;
        w_g2      = OFF_W'(1) << w_sh;
        w_ox      = {w_cx_snap[CAM_W-1], w_cx_snap} + w_g2;
        w_oz      = {w_cz_snap[CAM_W-1], w_cz_snap} + w_g2;
        w_oz_d    = w_oz - ((i_cmd.level != '0) ? OFF_W'(1) : '0);
        w_2ox     = {{(NUM_W - OFF_W - 1){w_ox[OFF_W-1]}}, w_ox, 1'b0};
        w_2oz     = {{(NUM_W - OFF_W - 1){w_oz_d[OFF_W-1]}}, w_oz_d, 1'b0};
        w_ngi     = NUM_W'(r_clip) << i_cmd.level;
        w_base    = NUM_W'(r_base);
        // Trim side set when bit 'level' of the camera coordinate is clear
        w_tx      = ~|(r_cam_x & (CAM_W'(1) << i_cmd.level));
        w_tz      = ~|(r_cam_z & (CAM_W'(1) << i_cmd.level));
        w_copy    = r_force | (w_tx != r_trim_x[w_idx]) | (w_tz != r_trim_z[w_idx]);
    end

    // Finish the box of the registered level
    always_comb begin
        w_bx = f_box(r_num_x, r_hi_x, {r_base, 1'b0}, w_sh);
        w_bz = f_box(r_num_z, r_hi_z, {r_base, 1'b0}, w_sh);
        if (!r_copy) begin
            w_bx = '0;
            w_bz = '0;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= CLIP_SIZE_RST;
            r_base <= BASE_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CLIP_SIZE: r_clip <= i_cfg_data[CLIP_W-1:0];
                CFG_BASE_SIZE: r_base <= i_cfg_data[BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Trim bits, one pair per level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_trim_x[k] <= 1'b0;
                r_trim_z[k] <= 1'b0;
            end
        end else if (i_cmd.calc) begin
            r_trim_x[w_idx] <= w_tx;
            r_trim_z[w_idx] <= w_tz;
        end
    end

    // Capture the camera item, the level intermediates and the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cam_x <= i_cam_x;
            r_cam_z <= i_cam_z;
            r_force <= i_force;
        end
        if (i_cmd.calc) begin
            r_ox    <= w_ox;
            r_oz    <= w_oz;
            r_tx    <= w_tx;
            r_tz    <= w_tz;
            r_copy  <= w_copy;
            r_num_x <= w_2ox + w_base - w_ngi;
            r_hi_x  <= w_2ox + w_base + w_ngi;
            r_num_z <= w_2oz + w_base - w_ngi;
            r_hi_z  <= w_2oz + w_base + w_ngi;
        end
        if (i_cmd.fin) begin
            r_out_data <= OUT_TDATA_W'({w_bz.dst, w_bx.dst, w_bz.hi, w_bz.lo,
                                        w_bx.hi, w_bx.lo, r_copy, r_tz, r_tx,
                                        r_oz, r_ox, i_cmd.level});
            r_out_last <= i_cmd.last;
        end
    end

    assign o_data = r_out_data;
    assign o_last = r_out_last;

endmodule

/* rtl/clipmap_level_update_core.sv */
// Top level of the clipmap level update block: sequencer, datapath and checks.
//
// Use: one camera item (floored x and z, force flag) enters on the s_axis
// channel; the block returns LEVELS-1 result items on m_axis, level 0 first,
// with tlast on the coarsest level. Each result gives the snapped level
// centre, the trim sides, whether the level must be copied and, for a copy,
// the clamped source box in the base mip level and the destination corner.
// The cfg channel writes clip_size (index 0) and base_size (index 1); it is
// always ready; the user must write it only while no update is in flight,
// as the block itself does not enforce this. For each level the shared box
// datapath forms the numerators and then clamps and truncates the box, and
// the sequencer works through the levels one at a time.
// A single output register parts the two sides: the next level is worked
// out while a result waits, and the sequencer holds when the slot stays
// full. A new camera item is taken as soon as the last level has been
// handed to the output register.
// Reset clears the trim bits, the sequencer and the output slot and loads
// clip_size 256 and base_size 4096.
module clipmap_level_update_core #(
    parameter int LEVELS = clu_pkg::LEVELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Camera items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // cam_x [23:0], cam_z [47:24], force_refresh [48], zero [55:49]
    input  logic [clu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // Level results
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // level [3:0], offset_x [28:4], offset_z [53:29], trim_sides [55:54],
    // copy_needed [56], src_left [71:57], src_right [86:72],
    // src_top [101:87], src_bottom [116:102], dst_x [140:117],
    // dst_y [164:141], zero [167:165]
    output logic [clu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,
    // Configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [clu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [clu_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import clu_pkg::*;

    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    // Sequence the levels
    clu_ctrl #(
        .LEVELS(LEVELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    // Compute each level
    clu_datapath #(
        .LEVELS(LEVELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cam_x     (s_axis_tdata[CAM_W-1:0]),
        .i_cam_z     (s_axis_tdata[2*CAM_W-1:CAM_W]),
        .i_force     (s_axis_tdata[2*CAM_W]),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

    // An accepted camera item closes the input until its levels are done
    a_in_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input still open after a camera item was taken");

    // The final result carries the coarsest level
    a_last_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
        (m_axis_tdata[LVL_W-1:0] == LVL_W'(LEVELS - 2)))
        else $error("tlast on a level other than the coarsest");

    // A level without a copy gives an empty box and no destination
    a_no_copy_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[56]) |-> (m_axis_tdata[164:57] == '0))
        else $error("box fields set on a level without a copy");

endmodule

/* tb/clu_level_checker.sv */
// Checker for the clipmap level update block: predicts every level result and compares.
module clu_level_checker #(
    parameter int LEVELS = clu_pkg::LEVELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Camera channel as seen at the block
    input  logic                           i_cam_valid,
    input  logic                           i_cam_ready,
    // cam_x [23:0], cam_z [47:24], force_refresh [48], zero [55:49]
    input  logic [clu_pkg::IN_TDATA_W-1:0] i_cam_data,
    // Level result channel as seen at the block
    input  logic                           i_lvl_valid,
    input  logic                           i_lvl_ready,
    // level [3:0], offset_x [28:4], offset_z [53:29], trim_sides [55:54],
    // copy_needed [56], src_left [71:57], src_right [86:72], src_top [101:87],
    // src_bottom [116:102], dst_x [140:117], dst_y [164:141], zero [167:165]
    input  logic [clu_pkg::OUT_TDATA_W-1:0] i_lvl_data,
    input  logic                           i_lvl_last,
    // Configuration channel as seen at the block
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [clu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [clu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Running mismatch count and results still owed by the block
    output int                             o_errors,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import clu_pkg::*;

    // A level result is the output word with tlast on top
    localparam int RES_W      = OUT_TDATA_W + 1;
    localparam int NUM_FIELDS = 12;

    logic [RES_W-1:0]  level_q [$];
    logic [LEVELS-2:0] trim_x_st = '0;
    logic [LEVELS-2:0] trim_z_st = '0;
    logic [CLIP_W-1:0] clip_sz   = CLIP_SIZE_RST;
    logic [BASE_W-1:0] base_sz   = BASE_SIZE_RST;
    int                err_cnt   = 0;

    // Bit position, width and name of each field in a level result
    function automatic void field_span(input int k, output int lsb, output int w,
                                       output string nm);
        case (k)
            0: begin lsb = 0;   w = LVL_W;  nm = "level";       end
            1: begin lsb = 4;   w = OFF_W;  nm = "offset_x";    end
            2: begin lsb = 29;  w = OFF_W;  nm = "offset_z";    end
            3: begin lsb = 54;  w = 2;      nm = "trim_sides";  end
            4: begin lsb = 56;  w = 1;      nm = "copy_needed"; end
            5: begin lsb = 57;  w = BASE_W; nm = "src_left";    end
            6: begin lsb = 72;  w = BASE_W; nm = "src_right";   end
            7: begin lsb = 87;  w = BASE_W; nm = "src_top";     end
            8: begin lsb = 102; w = BASE_W; nm = "src_bottom";  end
            9: begin lsb = 117; w = DST_W;  nm = "dst_x";       end
            10: begin lsb = 141; w = DST_W; nm = "dst_y";       end
            default: begin lsb = OUT_TDATA_W; w = 1; nm = "last"; end
        endcase
    endfunction

    function automatic longint bound_box(input longint v, input longint hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Source span and destination along one axis; num is a numerator over 2^sh
    function automatic void texel_span(input longint num, input int sh, input longint n,
                                       input longint s2, output logic [BASE_W-1:0] lo,
                                       output logic [BASE_W-1:0] hi,
                                       output logic [DST_W-1:0] dst);
        longint den;
        longint d;
        den = longint'(1) << sh;
        d   = 0;
        // Negative source start: the destination moves in, saturating
        if (num < 0) begin
            d = (den - num) >>> sh;
            if (d > 16777215)
                d = 16777215;
        end
        dst = d[DST_W-1:0];
        lo  = BASE_W'(bound_box(num, s2) >> sh);
        hi  = BASE_W'(bound_box(num + n * den, s2) >> sh);
    endfunction

    // Work out the result of every level for one camera item and queue them
    task automatic predict_levels(input logic [CAM_W-1:0] cam_x,
                                  input logic [CAM_W-1:0] cam_z, input logic frc);
        longint            cx, cz, n, s, g, g2, mx, mz, ox, oz, dz;
        logic              tx, tz, cp;
        logic [BASE_W-1:0] lo_x, hi_x, lo_z, hi_z;
        logic [DST_W-1:0]  d_x, d_z;
        cx = $signed(cam_x);
        cz = $signed(cam_z);
        n  = clip_sz;
        s  = base_sz;
        for (int i = 0; i < LEVELS - 1; i++) begin
            g  = longint'(1) << i;
            g2 = 2 * g;
            mx = cx & (g2 - 1);
            mz = cz & (g2 - 1);
            ox = cx + g2 - mx;
            oz = cz + g2 - mz;
            tx = (g2 - mx) > g;
            tz = (g2 - mz) > g;
            cp = frc || (tx != trim_x_st[i]) || (tz != trim_z_st[i]);
            trim_x_st[i] = tx;
            trim_z_st[i] = tz;
            lo_x = '0;
            hi_x = '0;
            lo_z = '0;
            hi_z = '0;
            d_x  = '0;
            d_z  = '0;
            if (cp) begin
                // z axis is shifted by one unit on every level but the finest
                dz = (i > 0) ? 1 : 0;
                texel_span(2 * ox - n * g + s, i + 1, n, 2 * s, lo_x, hi_x, d_x);
                texel_span(2 * (oz - dz) - n * g + s, i + 1, n, 2 * s, lo_z, hi_z, d_z);
            end
            level_q.push_back({(i == LEVELS - 2), 3'b000, d_z, d_x, hi_z, lo_z, hi_x, lo_x,
                               cp, tz, tx, oz[OFF_W-1:0], ox[OFF_W-1:0], LVL_W'(i)});
        end
    endtask

    // Watch all three channels at every edge
    always @(posedge i_clk) begin : watch
        logic [RES_W-1:0] want;
        logic [RES_W-1:0] got;
        longint           ef;
        longint           af;
        int               lsb;
        int               w;
        string            nm;
        if (!i_rst_n) begin
            level_q.delete();
            trim_x_st = '0;
            trim_z_st = '0;
            clip_sz   = CLIP_SIZE_RST;
            base_sz   = BASE_SIZE_RST;
        end else begin
            // Compare a taken result with the oldest prediction
            if (i_lvl_valid && i_lvl_ready) begin
                got = {i_lvl_last, i_lvl_data};
                if (level_q.size() == 0) begin
                    $display("%0t: level result with none expected: expected nothing, got %0h",
                             $time, got);
                    err_cnt++;
                end else begin
                    want = level_q.pop_front();
                    for (int k = 0; k < NUM_FIELDS; k++) begin
                        field_span(k, lsb, w, nm);
                        ef = longint'((want >> lsb) & ~({RES_W{1'b1}} << w));
                        af = longint'((got >> lsb) & ~({RES_W{1'b1}} << w));
                        if (ef != af) begin
                            $display("%0t: %s of level %0d: expected %0d, got %0d",
                                     $time, nm, want[LVL_W-1:0], ef, af);
                            err_cnt++;
                        end
                    end
                end
            end
            if (i_cam_valid && i_cam_ready)
                predict_levels(i_cam_data[CAM_W-1:0], i_cam_data[2*CAM_W-1:CAM_W],
                               i_cam_data[2*CAM_W]);
            // Track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_CLIP_SIZE)
                    clip_sz = i_cfg_data[CLIP_W-1:0];
                else
                    base_sz = i_cfg_data[BASE_W-1:0];
            end
        end
        o_errors  <= err_cnt;
        o_pending <= level_q.size();
    end

endmodule

/* tb/tb_clipmap_level_update_core.sv */
// Testbench top for the clipmap level update block: stimulus, receiver and verdict.
module tb_clipmap_level_update_core;
    timeunit 1ns;
    timeprecision 1ps;
    import clu_pkg::*;

    localparam int LIMIT       = 100000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_LEN    = 300;
    localparam int TAIL        = 40;
    localparam int PHASE_ITEMS = 22;
    localparam int NUM_PHASES  = 6;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cam_valid = 1'b0;
    logic                   cam_ready;
    logic [IN_TDATA_W-1:0]  cam_data  = '0;
    logic                   lvl_valid;
    logic                   lvl_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] lvl_data;
    logic                   lvl_last;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_CLIP_SIZE;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    int                     errors;
    int                     pending;

    int                     cycles    = 0;
    int                     rx_wait   = 0;
    int                     rx_hold   = 0;
    int                     rx_taken  = 0;
    logic                   rx_eager  = 1'b0;
    logic                   tx_eager  = 1'b0;
    logic [CAM_W-1:0]       cur_x     = '0;
    logic [CAM_W-1:0]       cur_z     = '0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    clipmap_level_update_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (cam_valid),
        .s_axis_tready (cam_ready),
        .s_axis_tdata  (cam_data),
        .m_axis_tvalid (lvl_valid),
        .m_axis_tready (lvl_ready),
        .m_axis_tdata  (lvl_data),
        .m_axis_tlast  (lvl_last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    clu_level_checker #(
        .LEVELS (LEVELS_DEF)
    ) u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cam_valid (cam_valid),
        .i_cam_ready (cam_ready),
        .i_cam_data  (cam_data),
        .i_lvl_valid (lvl_valid),
        .i_lvl_ready (lvl_ready),
        .i_lvl_data  (lvl_data),
        .i_lvl_last  (lvl_last),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Give up on a hung run
    always @(posedge clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result receiver: random gap per item, eager stretches, one long hold-off
    always @(posedge clk) begin : rx_side
        int nxt;
        if (!rst_n) begin
            lvl_ready <= 1'b0;
            rx_wait   <= 0;
            rx_hold   <= 0;
            rx_taken  <= 0;
        end else if (rx_hold > 0) begin
            lvl_ready <= (rx_hold == 1);
            rx_hold   <= rx_hold - 1;
        end else if (lvl_ready && lvl_valid) begin
            rx_taken <= rx_taken + 1;
            if (rx_taken == HOLD_AT) begin
                // Stall long enough for the block to back up into its input
                rx_hold   <= HOLD_LEN;
                lvl_ready <= 1'b0;
            end else begin
                nxt       = rx_eager ? 0 : $urandom_range(0, 10);
                rx_wait   <= nxt;
                lvl_ready <= (nxt == 0);
            end
            if ($urandom_range(0, 31) == 0)
                rx_eager <= !rx_eager;
        end else if (rx_wait > 0) begin
            lvl_ready <= (rx_wait == 1);
            rx_wait   <= rx_wait - 1;
        end else begin
            lvl_ready <= 1'b1;
        end
    end

    // Offer one camera item after a random gap and hold it until taken
    task automatic send_cam(input logic [CAM_W-1:0] cx, input logic [CAM_W-1:0] cz,
                            input logic frc);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_eager = !tx_eager;
        gap = tx_eager ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            cam_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cam_valid <= 1'b1;
        cam_data  <= IN_TDATA_W'({frc, cz, cx});
        @(posedge clk);
        while (!cam_ready)
            @(posedge clk);
    endtask

    // Stop offering and hold until every predicted result has come back
    task automatic settle();
        cam_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic write_cfg(input logic [CFG_DATA_W-1:0] clip_v,
                             input logic [CFG_DATA_W-1:0] base_v);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CLIP_SIZE;
        cfg_data  <= clip_v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_BASE_SIZE;
        cfg_data  <= base_v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CAM_W-1:0] rail_coord();
        case ($urandom_range(0, 3))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            default: return 24'hFFFFFF;
        endcase
    endfunction

    // Mostly a camera drifting in small steps, with jumps and rails as noise
    task automatic send_random_cam();
        int span;
        case ($urandom_range(0, 15))
            0: begin
                cur_x = CAM_W'($urandom);
                cur_z = CAM_W'($urandom);
            end
            1: begin
                cur_x = rail_coord();
                cur_z = rail_coord();
            end
            default: begin
                span  = 1 << (2 * $urandom_range(0, 4));
                cur_x = cur_x + CAM_W'($urandom_range(0, 2 * span) - span);
                cur_z = cur_z + CAM_W'($urandom_range(0, 2 * span) - span);
            end
        endcase
        send_cam(cur_x, cur_z, $urandom_range(0, 7) == 0);
    endtask

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] clip_v;
        logic [CFG_DATA_W-1:0] base_v;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset sizes
        send_cam(CAM_W'(0), CAM_W'(0), 1'b0);         // every trim flips from reset
        send_cam(CAM_W'(0), CAM_W'(0), 1'b0);         // nothing changes, no copy
        send_cam(CAM_W'(0), CAM_W'(0), 1'b1);         // forced copy without a change
        send_cam(CAM_W'(1), CAM_W'(1), 1'b0);
        send_cam(CAM_W'(-1), CAM_W'(-1), 1'b0);
        send_cam(CAM_W'(2), CAM_W'(3), 1'b0);
        send_cam(24'h7FFFFF, 24'h7FFFFF, 1'b0);
        send_cam(24'h800000, 24'h800000, 1'b0);
        send_cam(24'h7FFFFF, 24'h800000, 1'b1);
        send_cam(24'h800000, 24'h7FFFFF, 1'b0);
        send_cam(CAM_W'(127), CAM_W'(-128), 1'b0);
        send_cam(CAM_W'(-2048), CAM_W'(2048), 1'b1);  // source start below zero
        send_cam(CAM_W'(-3000), CAM_W'(-3000), 1'b0);
        send_cam(CAM_W'(5000), CAM_W'(5000), 1'b1);   // box clamped at the mip edge
        send_cam(CAM_W'(64), CAM_W'(-65), 1'b0);
        send_cam(24'h555555, 24'hAAAAAA, 1'b1);
        send_cam(24'hAAAAAA, 24'h555555, 1'b0);
        send_cam(CAM_W'(3), CAM_W'(3), 1'b0);
        send_cam(CAM_W'(4), CAM_W'(4), 1'b0);
        send_cam(CAM_W'(0), CAM_W'(0), 1'b0);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin clip_v = 2;        base_v = 1;        end
                1: begin clip_v = 4096;     base_v = 16384;    end
                2: begin clip_v = 0;        base_v = 0;        end
                3: begin clip_v = 15'h7FFF; base_v = 15'h7FFF; end
                4: begin
                    clip_v = CFG_DATA_W'(2 * $urandom_range(1, 2048));
                    base_v = CFG_DATA_W'($urandom_range(1, 16384));
                end
                default: begin clip_v = 256; base_v = 4096; end
            endcase
            write_cfg(clip_v, base_v);
            repeat (PHASE_ITEMS)
                send_random_cam();
        end

        settle();
        repeat (TAIL) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/clu_pkg.sv
rtl/clu_ctrl.sv
rtl/clu_datapath.sv
rtl/clipmap_level_update_core.sv
tb/clu_level_checker.sv
tb/tb_clipmap_level_update_core.sv
